// ----- sv/lphi_pkg.sv -----
// ============================================================================
// lphi_pkg: shared types and constants of the linear probe hash index
// Request and status codes, hash constants, and the records that pass
// between the hash front end, the request queue and the probe engine.
// ============================================================================
package lphi_pkg;

  // Field widths
  localparam int KEY_W    = 64;
  localparam int WORD_W   = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 12;
  localparam int CAP_W    = 4;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Capacity register reset value and its register index
  localparam logic [CAP_W-1:0] CAP_RESET   = 4'd12;
  localparam logic             CFG_REG_CAP = 1'b0;

  // Occupancy stamp width; a wrap of the stamp forces a clearing sweep
  localparam int EPOCH_W = 8;

  // Request queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Murmur3 64-bit finalizer constants
  localparam logic [KEY_W-1:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int               FMIX_SHIFT = 33;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // Three payload words kept with a key
  typedef struct packed {
    logic [WORD_W-1:0] payload_offset;
    logic [WORD_W-1:0] row_offset;
    logic [WORD_W-1:0] map_len;
  } payload_t;

  // Classified request handed from the front end to the probe engine
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] hash;
    payload_t         pay;
  } lphi_req_t;

  // One slot of the table memory
  typedef struct packed {
    logic [EPOCH_W-1:0] stamp;
    logic [KEY_W-1:0]   key;
    payload_t           pay;
  } row_t;

endpackage

// ----- sv/linear_probe_hash_index.sv -----
// ============================================================================
// linear_probe_hash_index: open-addressing hash index with 64-bit keys
// Murmur3 fmix64 home slot, linear probing within the capacity in use.
//
//   channel  | handshake                  | transfer carries
//   ---------+----------------------------+-------------------------------------
//   in_      | in_valid / in_stall        | req_type, key, three payload words
//   out_     | out_valid / out_stall      | status, three found words, slot_index
//   cfg APB  | psel, penable, pwrite      | capacity_log2 at byte address 0
//
// The hash front end runs two rounds of a shared 32x32 partial-product bank
// and mix per insert or lookup; clear skips the hash.
// The probe engine checks one slot per cycle through the registered table
// read port.
// After reset, and after every 255th clear, a sweep rewrites the occupancy
// stamps of all 2^SLOT_BITS slots; in_stall stays high during it.
// A stalled result holds in the output register while the front end keeps
// hashing into a two-entry queue.
// ============================================================================
module linear_probe_hash_index #(
  parameter int SLOT_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lphi_pkg::REQ_W-1:0]          in_req_type,
  input  logic [lphi_pkg::KEY_W-1:0]          in_key,
  input  logic [lphi_pkg::WORD_W-1:0]         in_payload_offset,
  input  logic [lphi_pkg::WORD_W-1:0]         in_row_offset,
  input  logic [lphi_pkg::WORD_W-1:0]         in_entry_bitmap_len,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lphi_pkg::STATUS_W-1:0]       out_status,
  output logic [lphi_pkg::WORD_W-1:0]         out_found_payload_offset,
  output logic [lphi_pkg::WORD_W-1:0]         out_found_row_offset,
  output logic [lphi_pkg::WORD_W-1:0]         out_found_bitmap_len,
  output logic [lphi_pkg::IDX_W-1:0]          out_slot_index,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lphi_pkg::APB_AW-1:0]         paddr,
  input  logic [lphi_pkg::APB_DW-1:0]         pwdata,
  output logic [lphi_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  logic [lphi_pkg::CAP_W-1:0] cap_r;
  logic                       sweeping;
  logic                       push_valid;
  logic                       push_ready;
  lphi_pkg::lphi_req_t        push_entry;
  logic                       pop_valid;
  logic                       pop_ready;
  lphi_pkg::lphi_req_t        pop_entry;
  logic                       cfg_wr;

  // Capacity register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lphi_pkg::CFG_REG_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lphi_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[lphi_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lphi_pkg::CFG_REG_CAP)
                ? {{(lphi_pkg::APB_DW - lphi_pkg::CAP_W){1'b0}}, cap_r}
                : '0;

  lphi_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .hold                (sweeping),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_key              (in_key),
    .in_payload_offset   (in_payload_offset),
    .in_row_offset       (in_row_offset),
    .in_entry_bitmap_len (in_entry_bitmap_len),
    .push_valid          (push_valid),
    .push_ready          (push_ready),
    .push_entry          (push_entry)
  );

  lphi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  lphi_back #(
    .SLOT_BITS (SLOT_BITS)
  ) u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cap_log2                 (cap_r),
    .sweeping                 (sweeping),
    .pop_valid                (pop_valid),
    .pop_ready                (pop_ready),
    .pop_entry                (pop_entry),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_status               (out_status),
    .out_found_payload_offset (out_found_payload_offset),
    .out_found_row_offset     (out_found_row_offset),
    .out_found_bitmap_len     (out_found_bitmap_len),
    .out_slot_index           (out_slot_index)
  );

endmodule

// ----- sv/lphi_front.sv -----
// ============================================================================
// lphi_front: request intake and key hashing
// Takes one request, runs the 64-bit finalizer on the key of an insert or
// lookup with a shared bank of 32x32 partial products (two multiply/mix
// rounds), and pushes the classified request into the queue.
// ============================================================================
module lphi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                hold,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lphi_pkg::REQ_W-1:0]          in_req_type,
  input  logic [lphi_pkg::KEY_W-1:0]          in_key,
  input  logic [lphi_pkg::WORD_W-1:0]         in_payload_offset,
  input  logic [lphi_pkg::WORD_W-1:0]         in_row_offset,
  input  logic [lphi_pkg::WORD_W-1:0]         in_entry_bitmap_len,
  output logic                                push_valid,
  input  logic                                push_ready,
  output lphi_pkg::lphi_req_t                 push_entry
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_MIX,
    F_PUSH
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic    pass_r, pass_nxt;

  logic [lphi_pkg::KEY_W-1:0]  v_r, v_nxt;
  logic [lphi_pkg::KEY_W-1:0]  p0_r, p0_nxt;
  logic [lphi_pkg::WORD_W-1:0] p1_r, p1_nxt;
  logic [lphi_pkg::WORD_W-1:0] p2_r, p2_nxt;
  logic [lphi_pkg::REQ_W-1:0]  req_r, req_nxt;
  logic [lphi_pkg::KEY_W-1:0]  key_r, key_nxt;
  lphi_pkg::payload_t          pay_r, pay_nxt;

  logic [lphi_pkg::KEY_W-1:0]  mul_c;
  logic [lphi_pkg::KEY_W-1:0]  prod0;
  logic [lphi_pkg::KEY_W-1:0]  prod1;
  logic [lphi_pkg::KEY_W-1:0]  prod2;
  logic [lphi_pkg::KEY_W-1:0]  mix;
  logic                        can_take;
  logic                        take;

  // Accept when not held and either idle or the finished request leaves this cycle
  assign can_take = !hold && ((state_r == F_IDLE) || ((state_r == F_PUSH) && push_ready));
  assign in_stall = !can_take;
  assign take     = in_valid && can_take;

  // Partial products of the low 64 bits of v times the round constant
  assign mul_c = pass_r ? lphi_pkg::FMIX_C2 : lphi_pkg::FMIX_C1;
  assign prod0 = v_r[31:0]  * mul_c[31:0];
  assign prod1 = v_r[63:32] * mul_c[31:0];
  assign prod2 = v_r[31:0]  * mul_c[63:32];
  assign mix   = p0_r + {p1_r + p2_r, 32'b0};

  // Next-state and datapath
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    v_nxt     = v_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    req_nxt   = req_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;

    case (state_r)
      F_MUL: begin
        p0_nxt    = prod0;
        p1_nxt    = prod1[31:0];
        p2_nxt    = prod2[31:0];
        state_nxt = F_MIX;
      end
      F_MIX: begin
        v_nxt = mix ^ (mix >> lphi_pkg::FMIX_SHIFT);
        if (pass_r) begin
          state_nxt = F_PUSH;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = F_MUL;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
      end
    endcase

    // Load a new request; clear and unused codes skip the hash
    if (take) begin
      req_nxt                = in_req_type;
      key_nxt                = in_key;
      pay_nxt.payload_offset = in_payload_offset;
      pay_nxt.row_offset     = in_row_offset;
      pay_nxt.map_len        = in_entry_bitmap_len;
      v_nxt                  = in_key ^ (in_key >> lphi_pkg::FMIX_SHIFT);
      pass_nxt               = 1'b0;
      if ((in_req_type == lphi_pkg::REQ_INSERT) || (in_req_type == lphi_pkg::REQ_LOOKUP)) begin
        state_nxt = F_MUL;
      end else begin
        state_nxt = F_PUSH;
      end
    end
  end

  // Hold state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
    v_r   <= v_nxt;
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    req_r <= req_nxt;
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign push_valid          = (state_r == F_PUSH);
  assign push_entry.req_type = req_r;
  assign push_entry.key      = key_r;
  assign push_entry.hash     = v_r;
  assign push_entry.pay      = pay_r;

endmodule

// ----- sv/lphi_queue.sv -----
// ============================================================================
// lphi_queue: short request queue
// Two-entry FIFO that decouples the hash front end from the probe engine.
// ============================================================================
module lphi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  lphi_pkg::lphi_req_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lphi_pkg::lphi_req_t pop_entry
);

  lphi_pkg::lphi_req_t               buf_r [lphi_pkg::Q_DEPTH];
  logic [lphi_pkg::Q_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [lphi_pkg::Q_CNT_W-1:0]      count_r;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = (count_r != lphi_pkg::Q_CNT_W'(lphi_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = buf_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == lphi_pkg::Q_PTR_W'(lphi_pkg::Q_DEPTH - 1)) ? '0
                                                                               : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == lphi_pkg::Q_PTR_W'(lphi_pkg::Q_DEPTH - 1)) ? '0
                                                                               : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- sv/lphi_back.sv -----
// ============================================================================
// lphi_back: probe engine and slot table
// Walks the table one slot per cycle from the home slot, inserts or looks
// up the key, handles clear by advancing an occupancy stamp, and holds the
// result register. A sweep rewrites every stamp after reset and on a
// stamp wrap.
// ============================================================================
module lphi_back #(
  parameter int SLOT_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [lphi_pkg::CAP_W-1:0]           cap_log2,
  output logic                                 sweeping,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  lphi_pkg::lphi_req_t                  pop_entry,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lphi_pkg::STATUS_W-1:0]        out_status,
  output logic [lphi_pkg::WORD_W-1:0]          out_found_payload_offset,
  output logic [lphi_pkg::WORD_W-1:0]          out_found_row_offset,
  output logic [lphi_pkg::WORD_W-1:0]          out_found_bitmap_len,
  output logic [lphi_pkg::IDX_W-1:0]           out_slot_index
);

  localparam int SLOTS = 1 << SLOT_BITS;

  typedef enum logic [1:0] {
    B_SWEEP,
    B_IDLE,
    B_CHECK,
    B_RESULT
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [lphi_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [SLOT_BITS-1:0]         sweep_r, sweep_nxt;
  logic                         sweep_after_r, sweep_after_nxt;
  logic [SLOT_BITS-1:0]         cur_r, cur_nxt;
  logic [SLOT_BITS-1:0]         cnt_r, cnt_nxt;
  lphi_pkg::lphi_req_t          req_r, req_nxt;
  lphi_pkg::status_t            res_status_r, res_status_nxt;
  lphi_pkg::payload_t           res_pay_r, res_pay_nxt;
  logic [lphi_pkg::IDX_W-1:0]   res_slot_r, res_slot_nxt;

  logic                         out_valid_r, out_valid_nxt;
  lphi_pkg::status_t            out_status_r, out_status_nxt;
  lphi_pkg::payload_t           out_pay_r, out_pay_nxt;
  logic [lphi_pkg::IDX_W-1:0]   out_slot_r, out_slot_nxt;

  // Table memory
  lphi_pkg::row_t               mem [SLOTS];
  lphi_pkg::row_t               rd_row_r;
  logic [SLOT_BITS-1:0]         rd_addr;
  logic                         wr_en;
  logic [SLOT_BITS-1:0]         wr_addr;
  lphi_pkg::row_t               wr_row;

  logic [4:0]                   eff_bits;
  logic [SLOT_BITS-1:0]         mask;
  logic [SLOT_BITS-1:0]         home;
  logic [SLOT_BITS-1:0]         next_slot;
  logic [SLOT_BITS+lphi_pkg::IDX_W-1:0] cur_wide;
  logic [lphi_pkg::IDX_W-1:0]   cur_idx;
  logic                         occ;
  logic                         hit;
  logic                         is_insert;
  logic                         out_free;

  // Clamp the capacity and build the probe mask
  always_comb begin
    if (cap_log2 == '0) begin
      eff_bits = 5'd1;
    end else if ({1'b0, cap_log2} > 5'(SLOT_BITS)) begin
      eff_bits = 5'(SLOT_BITS);
    end else begin
      eff_bits = {1'b0, cap_log2};
    end
    for (int i = 0; i < SLOT_BITS; i++) begin
      mask[i] = (5'(i) < eff_bits);
    end
  end

  assign home      = pop_entry.hash[SLOT_BITS-1:0] & mask;
  assign next_slot = (cur_r + SLOT_BITS'(1)) & mask;
  assign cur_wide  = {{lphi_pkg::IDX_W{1'b0}}, cur_r};
  assign cur_idx   = cur_wide[lphi_pkg::IDX_W-1:0];
  assign occ       = (rd_row_r.stamp == epoch_r);
  assign hit       = occ && (rd_row_r.key == req_r.key);
  assign is_insert = (req_r.req_type == lphi_pkg::REQ_INSERT);
  assign out_free  = !out_valid_r || !out_stall;

  assign pop_ready = (state_r == B_IDLE);
  assign sweeping  = (state_r == B_SWEEP);

  // Read address: home slot on pop, the following slot while probing
  always_comb begin
    case (state_r)
      B_IDLE:  rd_addr = home;
      B_CHECK: rd_addr = next_slot;
      default: rd_addr = cur_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    epoch_nxt       = epoch_r;
    sweep_nxt       = sweep_r;
    sweep_after_nxt = sweep_after_r;
    cur_nxt         = cur_r;
    cnt_nxt         = cnt_r;
    req_nxt         = req_r;
    res_status_nxt  = res_status_r;
    res_pay_nxt     = res_pay_r;
    res_slot_nxt    = res_slot_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_pay_nxt     = out_pay_r;
    out_slot_nxt    = out_slot_r;
    wr_en           = 1'b0;
    wr_addr         = cur_r;
    wr_row          = '0;

    // Drop a taken result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      B_SWEEP: begin
        // Mark every slot empty under stamp zero
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) begin
          epoch_nxt = lphi_pkg::EPOCH_W'(1);
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_valid) begin
          req_nxt        = pop_entry;
          cur_nxt        = home;
          cnt_nxt        = '0;
          res_pay_nxt    = '0;
          res_slot_nxt   = '0;
          res_status_nxt = lphi_pkg::ST_NOT_FOUND;
          case (pop_entry.req_type)
            lphi_pkg::REQ_CLEAR: begin
              res_status_nxt = lphi_pkg::ST_CLEARED;
              if (&epoch_r) begin
                sweep_after_nxt = 1'b1;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
              end
              state_nxt = B_RESULT;
            end
            lphi_pkg::REQ_INSERT: state_nxt = B_CHECK;
            lphi_pkg::REQ_LOOKUP: state_nxt = B_CHECK;
            default:              state_nxt = B_RESULT;
          endcase
        end
      end
      B_CHECK: begin
        if (!occ) begin
          // Empty slot ends the probe
          if (is_insert) begin
            wr_en          = 1'b1;
            wr_addr        = cur_r;
            wr_row.stamp   = epoch_r;
            wr_row.key     = req_r.key;
            wr_row.pay     = req_r.pay;
            res_status_nxt = lphi_pkg::ST_INSERTED;
            res_slot_nxt   = cur_idx;
          end else begin
            res_status_nxt = lphi_pkg::ST_NOT_FOUND;
          end
          state_nxt = B_RESULT;
        end else if (hit) begin
          res_slot_nxt = cur_idx;
          if (is_insert) begin
            res_status_nxt = lphi_pkg::ST_DUPLICATE;
          end else begin
            res_status_nxt = lphi_pkg::ST_FOUND;
            res_pay_nxt    = rd_row_r.pay;
          end
          state_nxt = B_RESULT;
        end else if (cnt_r == mask) begin
          res_status_nxt = lphi_pkg::ST_FULL;
          state_nxt      = B_RESULT;
        end else begin
          cur_nxt = next_slot;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pay_nxt    = res_pay_r;
          out_slot_nxt   = res_slot_r;
          if (sweep_after_r) begin
            sweep_after_nxt = 1'b0;
            sweep_nxt       = '0;
            state_nxt       = B_SWEEP;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Hold state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_SWEEP;
      epoch_r       <= '0;
      sweep_r       <= '0;
      sweep_after_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      epoch_r       <= epoch_nxt;
      sweep_r       <= sweep_nxt;
      sweep_after_r <= sweep_after_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    req_r        <= req_nxt;
    res_status_r <= res_status_nxt;
    res_pay_r    <= res_pay_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r    <= out_pay_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_row_r <= mem[rd_addr];
  end

  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_found_payload_offset = out_pay_r.payload_offset;
  assign out_found_row_offset     = out_pay_r.row_offset;
  assign out_found_bitmap_len     = out_pay_r.map_len;
  assign out_slot_index           = out_slot_r;

endmodule

// ----- sv/lphi_checker.sv -----
// ============================================================================
// lphi_checker: port-level checks of the hash index
// Watches the result channel for held transfers and consistent fields.
// ============================================================================
module lphi_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [lphi_pkg::STATUS_W-1:0]       out_status,
  input logic [lphi_pkg::WORD_W-1:0]         out_found_payload_offset,
  input logic [lphi_pkg::WORD_W-1:0]         out_found_row_offset,
  input logic [lphi_pkg::WORD_W-1:0]         out_found_bitmap_len,
  input logic [lphi_pkg::IDX_W-1:0]          out_slot_index
);

  // Stalled result stays and keeps its status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_slot_index))
    else $error("result changed while stalled");

  // Only defined status codes leave the block
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= lphi_pkg::ST_FULL))
    else $error("undefined status code");

  // Payload words are zero unless the key was found
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lphi_pkg::ST_FOUND) |->
      (out_found_payload_offset == '0) && (out_found_row_offset == '0) &&
      (out_found_bitmap_len == '0))
    else $error("payload words set without a hit");

  // No slot is named for clear, miss or full table
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == lphi_pkg::ST_CLEARED) ||
                  (out_status == lphi_pkg::ST_NOT_FOUND) ||
                  (out_status == lphi_pkg::ST_FULL)) |-> (out_slot_index == '0))
    else $error("slot index set on a result without a slot");

endmodule

bind linear_probe_hash_index lphi_checker u_lphi_checker (.*);
